>>> src/pfv_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the potential field velocity block.
package pfv_pkg;

  // Item codes on the operation field.
  localparam logic [1:0] OP_OBSTACLE = 2'd0;
  localparam logic [1:0] OP_PATH     = 2'd1;
  localparam logic [1:0] OP_END      = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_OCC_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_OBSTACLE_GAIN = 3'd1;
  localparam logic [2:0] CFG_GOAL_GAIN     = 3'd2;
  localparam logic [2:0] CFG_OUTPUT_SCALE  = 3'd3;
  localparam logic [2:0] CFG_VEL_LIMIT     = 3'd4;
  localparam logic [2:0] CFG_DIST_TOL      = 3'd5;

  // Register values after reset.
  localparam logic [15:0] RST_OCC_THRESHOLD = 16'd32768;
  localparam logic [23:0] RST_OBSTACLE_GAIN = 24'd196608;
  localparam logic [23:0] RST_GOAL_GAIN     = 24'd3276800;
  localparam logic [15:0] RST_OUTPUT_SCALE  = 16'd1638;
  localparam logic [20:0] RST_VEL_LIMIT     = 21'd32768;
  localparam logic [15:0] RST_DIST_TOL      = 16'd1;

  localparam logic [39:0] FORCE_CAP = {40{1'b1}};
  localparam logic [63:0] DIST_NONE = {64{1'b1}};

  // Final step counts of the shared arithmetic unit.
  localparam logic [6:0] MUL_LAST  = 7'd4;
  localparam logic [6:0] DIV_LAST  = 7'd127;
  localparam logic [6:0] SQRT_LAST = 7'd31;

  typedef enum logic [1:0] {
    AR_MUL,
    AR_DIV,
    AR_SQRT
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

  function automatic logic [39:0] sat40(input logic [127:0] v);
    return (|v[127:40]) ? FORCE_CAP : v[39:0];
  endfunction

  function automatic logic [63:0] sat64(input logic [127:0] v);
    return (|v[127:64]) ? DIST_NONE : v[63:0];
  endfunction

endpackage

>>> src/pfv_in_if.sv
`timescale 1ns / 1ps
// Input channel: one point or end-of-frame item per transfer.
interface pfv_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [15:0]        occupancy;

  modport source (output valid, operation, point_x, point_y, point_z, occupancy,
                  input ready);
  modport sink (input valid, operation, point_x, point_y, point_z, occupancy,
                output ready);
endinterface

>>> src/pfv_out_if.sv
`timescale 1ns / 1ps
// Result channel: one velocity command per transfer.
interface pfv_out_if;
  logic               valid;
  logic               ready;
  logic signed [21:0] velocity_x;
  logic signed [21:0] velocity_y;

  modport source (output valid, velocity_x, velocity_y, input ready);
  modport sink (input valid, velocity_x, velocity_y, output ready);
endinterface

>>> src/pfv_arith.sv
`timescale 1ns / 1ps
// Shared iterative arithmetic unit: 64x64 multiply, 128/64 divide and 64-bit square root.
module pfv_arith import pfv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  arith_req_t   req,
  input  logic [127:0] opa,
  input  logic [63:0]  opb,
  output arith_stat_t  stat,
  output logic [127:0] res
);

  logic         busy_r;
  logic         done_r;
  arith_op_t    op_r;
  logic [6:0]   cnt_r;
  logic [127:0] num_r;
  logic [63:0]  d_r;
  logic [63:0]  rem_r;
  logic [127:0] quo_r;
  logic [127:0] acc_r;
  logic [63:0]  prod_r;
  logic [1:0]   sh_r;
  logic         pv_r;

  logic [65:0]  sub_a;
  logic [65:0]  sub_b;
  logic [66:0]  diff;
  logic         ge;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;

  // One subtractor serves both the division and the square root recurrences.
  always_comb begin
    if (op_r == AR_SQRT) begin
      sub_a = {rem_r, num_r[127:126]};
      sub_b = {quo_r[63:0], 2'b01};
    end else begin
      sub_a = {1'b0, rem_r, num_r[127]};
      sub_b = {2'b00, d_r};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[66];
  end

  assign pa = cnt_r[1] ? num_r[63:32] : num_r[31:0];
  assign pb = cnt_r[0] ? d_r[63:32] : d_r[31:0];
  assign pp = {32'd0, pa} * {32'd0, pb};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pv_r   <= 1'b0;
      op_r   <= AR_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= '0;
        num_r  <= opa;
        d_r    <= opb;
        rem_r  <= '0;
        quo_r  <= '0;
        acc_r  <= '0;
        pv_r   <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        unique case (op_r) inside
          AR_MUL: begin
            // Partial products are registered and added in the next cycle.
            if (cnt_r < MUL_LAST) begin
              prod_r <= pp;
              sh_r   <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
              pv_r   <= 1'b1;
            end
            if (pv_r) begin
              acc_r <= acc_r + ({64'd0, prod_r} << {sh_r, 5'd0});
            end
            if (cnt_r == MUL_LAST) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          AR_DIV, AR_SQRT: begin
            rem_r <= ge ? diff[63:0] : sub_a[63:0];
            quo_r <= {quo_r[126:0], ge};
            num_r <= (op_r == AR_SQRT) ? {num_r[125:0], 2'b00} : {num_r[126:0], 1'b0};
            if (cnt_r == ((op_r == AR_SQRT) ? SQRT_LAST : DIV_LAST)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: begin
            busy_r <= 1'b0;
          end
        endcase
      end
    end
  end

  assign res       = (op_r == AR_MUL) ? acc_r : quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> src/potential_field_velocity.sv
`timescale 1ns / 1ps
// Top level of the potential field velocity block.
// The block takes one item at a time and drops ready until that item is finished. An obstacle
// or path point has its three squares go through the shared 32x32 multiplier, four partial
// products each. The end-of-frame item uses the bit-serial divider of the shared arithmetic
// unit for up to six divisions, plus two 32-step square roots and ten products, and also waits
// while a previous command still waits in the output register. The result sits in an output
// register, so a new frame is taken while the velocity command waits for transfer.
module potential_field_velocity import pfv_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pfv_in_if.sink      in_ch,
  pfv_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_UPD, S_TOL, S_MAG1, S_MAG2, S_COS_SQ, S_COS_DIV,
    S_COS_SQRT, S_REP, S_ATT_MUL, S_ATT_DIV, S_VEL, S_EMIT
  } state_t;

  logic [15:0] thr_r;
  logic [23:0] obs_gain_r;
  logic [23:0] goal_gain_r;
  logic [15:0] scale_r;
  logic [20:0] vlim_r;
  logic [15:0] tol_r;

  state_t             state_r;
  logic               pend_r;
  logic [1:0]         op_r;
  logic signed [31:0] pt_r [3];
  logic [15:0]        occ_r;
  logic [1:0]         idx_r;
  logic               phase_r;
  logic [63:0]        q_acc_r;
  logic [63:0]        obs_q_r;
  logic [63:0]        path_q_r;
  logic signed [31:0] obs_v_r [2];
  logic signed [31:0] path_v_r [2];
  logic [127:0]       tmp_r;
  logic [39:0]        mag_r;
  logic [63:0]        cx_r;
  logic [31:0]        c_r;
  logic signed [41:0] force_r [2];
  logic signed [21:0] vel_r [2];
  logic               out_valid_r;
  logic signed [21:0] out_x_r;
  logic signed [21:0] out_y_r;

  arith_req_t   ar_req;
  arith_stat_t  ar_stat;
  logic [127:0] ar_opa;
  logic [63:0]  ar_opb;
  logic [127:0] ar_res;

  logic         ax;
  logic [63:0]  qsel;
  logic         in_tol;
  logic [41:0]  fmag;
  logic [111:0] vq;
  logic [20:0]  vclamp;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [41:0] sterm(input logic [39:0] m, input logic neg);
    return neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
  endfunction

  assign ax     = idx_r[0];
  assign qsel   = phase_r ? path_q_r : obs_q_r;
  assign in_tol = {32'd0, qsel, 32'd0} <= ar_res;
  assign fmag   = force_r[ax][41] ? 42'(-force_r[ax]) : 42'(force_r[ax]);
  assign vq     = ar_res[127:16];
  assign vclamp = (vq > 112'(vlim_r)) ? vlim_r : vq[20:0];

  // Operands for the shared unit follow the sequencer step.
  always_comb begin
    ar_req.start = 1'b0;
    ar_req.op    = AR_MUL;
    ar_opa       = '0;
    ar_opb       = '0;
    unique case (state_r)
      S_SQ: begin
        ar_req.start = !pend_r;
        ar_opa       = 128'(mag32(pt_r[idx_r]));
        ar_opb       = 64'(mag32(pt_r[idx_r]));
      end
      S_TOL: begin
        ar_req.start = !pend_r && (qsel != DIST_NONE);
        ar_opa       = 128'(64'(tol_r) << COORD_FRAC_BITS);
        ar_opb       = 64'(tol_r) << COORD_FRAC_BITS;
      end
      S_MAG1: begin
        ar_req.start = !pend_r;
        ar_req.op    = AR_DIV;
        ar_opa       = 128'(obs_gain_r) << (4 * COORD_FRAC_BITS);
        ar_opb       = obs_q_r;
      end
      S_MAG2: begin
        ar_req.start = !pend_r;
        ar_req.op    = AR_DIV;
        ar_opa       = tmp_r;
        ar_opb       = obs_q_r;
      end
      S_COS_SQ: begin
        ar_req.start = !pend_r;
        ar_opa       = 128'(mag32(obs_v_r[ax]));
        ar_opb       = 64'(mag32(obs_v_r[ax]));
      end
      S_COS_DIV: begin
        ar_req.start = !pend_r;
        ar_req.op    = AR_DIV;
        ar_opa       = {cx_r, 64'd0};
        ar_opb       = obs_q_r;
      end
      S_COS_SQRT: begin
        ar_req.start = !pend_r;
        ar_req.op    = AR_SQRT;
        ar_opa       = {cx_r, 64'd0};
      end
      S_REP: begin
        ar_req.start = !pend_r;
        ar_opa       = 128'(mag_r);
        ar_opb       = 64'(c_r);
      end
      S_ATT_MUL: begin
        ar_req.start = !pend_r;
        ar_opa       = 128'(goal_gain_r);
        ar_opb       = 64'(mag32(path_v_r[ax]));
      end
      S_ATT_DIV: begin
        ar_req.start = !pend_r;
        ar_req.op    = AR_DIV;
        ar_opa       = 128'(cx_r) << COORD_FRAC_BITS;
        ar_opb       = path_q_r;
      end
      S_VEL: begin
        ar_req.start = !pend_r;
        ar_opa       = 128'(fmag);
        ar_opb       = 64'(scale_r);
      end
      default: begin
        ar_req.start = 1'b0;
      end
    endcase
  end

  pfv_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ar_req),
    .opa   (ar_opa),
    .opb   (ar_opb),
    .stat  (ar_stat),
    .res   (ar_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= RST_OCC_THRESHOLD;
      obs_gain_r  <= RST_OBSTACLE_GAIN;
      goal_gain_r <= RST_GOAL_GAIN;
      scale_r     <= RST_OUTPUT_SCALE;
      vlim_r      <= RST_VEL_LIMIT;
      tol_r       <= RST_DIST_TOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OCC_THRESHOLD: thr_r       <= cfg_data[15:0];
        CFG_OBSTACLE_GAIN: obs_gain_r  <= cfg_data;
        CFG_GOAL_GAIN:     goal_gain_r <= cfg_data;
        CFG_OUTPUT_SCALE:  scale_r     <= cfg_data[15:0];
        CFG_VEL_LIMIT:     vlim_r      <= cfg_data[20:0];
        CFG_DIST_TOL:      tol_r       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      idx_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      obs_q_r     <= DIST_NONE;
      path_q_r    <= DIST_NONE;
      obs_v_r     <= '{default: '0};
      path_v_r    <= '{default: '0};
    end else begin
      // In the emit step the output register is reloaded below instead.
      if (out_valid_r && out_ch.ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      if (ar_req.start) begin
        pend_r <= 1'b1;
      end else if (ar_stat.done) begin
        pend_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= in_ch.operation;
            pt_r[0] <= in_ch.point_x;
            pt_r[1] <= in_ch.point_y;
            pt_r[2] <= in_ch.point_z;
            occ_r   <= in_ch.occupancy;
            idx_r   <= '0;
            phase_r <= 1'b0;
            q_acc_r <= '0;
            force_r <= '{default: '0};
            if ((in_ch.operation == OP_OBSTACLE) || (in_ch.operation == OP_PATH)) begin
              state_r <= S_SQ;
            end else if (in_ch.operation == OP_END) begin
              state_r <= S_TOL;
            end
          end
        end
        S_SQ: begin
          if (ar_stat.done) begin
            q_acc_r <= q_acc_r + ar_res[63:0];
            idx_r   <= idx_r + 2'd1;
            if (idx_r == 2'd2) begin
              state_r <= S_UPD;
            end
          end
        end
        S_UPD: begin
          // Strict less-than keeps the first of several equally near points.
          if (op_r == OP_OBSTACLE) begin
            if ((occ_r >= thr_r) && (q_acc_r < obs_q_r)) begin
              obs_q_r    <= q_acc_r;
              obs_v_r[0] <= pt_r[0];
              obs_v_r[1] <= pt_r[1];
            end
          end else if (q_acc_r < path_q_r) begin
            path_q_r    <= q_acc_r;
            path_v_r[0] <= pt_r[0];
            path_v_r[1] <= pt_r[1];
          end
          state_r <= S_IDLE;
        end
        S_TOL: begin
          // A missing point or one within tolerance adds no force.
          if ((!pend_r && (qsel == DIST_NONE)) || (ar_stat.done && in_tol)) begin
            idx_r <= '0;
            if (phase_r) begin
              state_r <= S_VEL;
            end else begin
              phase_r <= 1'b1;
            end
          end else if (ar_stat.done) begin
            idx_r   <= '0;
            state_r <= phase_r ? S_ATT_MUL : S_MAG1;
          end
        end
        S_MAG1: begin
          if (ar_stat.done) begin
            tmp_r   <= ar_res;
            state_r <= S_MAG2;
          end
        end
        S_MAG2: begin
          if (ar_stat.done) begin
            mag_r   <= sat40(ar_res);
            state_r <= S_COS_SQ;
          end
        end
        S_COS_SQ: begin
          if (ar_stat.done) begin
            cx_r    <= ar_res[63:0];
            state_r <= S_COS_DIV;
          end
        end
        S_COS_DIV: begin
          if (ar_stat.done) begin
            cx_r    <= sat64(ar_res);
            state_r <= S_COS_SQRT;
          end
        end
        S_COS_SQRT: begin
          if (ar_stat.done) begin
            c_r     <= ar_res[31:0];
            state_r <= S_REP;
          end
        end
        S_REP: begin
          if (ar_stat.done) begin
            // The repulsive force points away from the obstacle.
            force_r[ax] <= force_r[ax] + sterm(sat40(ar_res >> 32),
                                               !obs_v_r[ax][31] && (obs_v_r[ax] != '0));
            if (ax) begin
              idx_r   <= '0;
              phase_r <= 1'b1;
              state_r <= S_TOL;
            end else begin
              idx_r   <= 2'd1;
              state_r <= S_COS_SQ;
            end
          end
        end
        S_ATT_MUL: begin
          if (ar_stat.done) begin
            cx_r    <= ar_res[63:0];
            state_r <= S_ATT_DIV;
          end
        end
        S_ATT_DIV: begin
          if (ar_stat.done) begin
            force_r[ax] <= force_r[ax] + sterm(sat40(ar_res), path_v_r[ax][31]);
            if (ax) begin
              idx_r   <= '0;
              state_r <= S_VEL;
            end else begin
              idx_r   <= 2'd1;
              state_r <= S_ATT_MUL;
            end
          end
        end
        S_VEL: begin
          if (ar_stat.done) begin
            vel_r[ax] <= force_r[ax][41] ? -$signed({1'b0, vclamp}) : $signed({1'b0, vclamp});
            if (ax) begin
              state_r <= S_EMIT;
            end else begin
              idx_r <= 2'd1;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_x_r     <= vel_r[0];
            out_y_r     <= vel_r[1];
            obs_q_r     <= DIST_NONE;
            path_q_r    <= DIST_NONE;
            obs_v_r     <= '{default: '0};
            path_v_r    <= '{default: '0};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.velocity_x = out_x_r;
  assign out_ch.velocity_y = out_y_r;

`ifndef SYNTHESIS
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    ar_stat.done |-> pend_r)
    else $error("arithmetic result arrived with no request outstanding");

  a_issue_free: assert property (@(posedge clk) disable iff (!rst_n)
    ar_req.start |-> !ar_stat.busy)
    else $error("arithmetic request issued while the unit is busy");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !out_valid_r) |=> out_valid_r)
    else $error("free output register was not loaded with the result");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the potential field velocity block with a built-in force predictor.
module tb_top;
  import pfv_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int SETTLE_CYCLES = 1000;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic signed [21:0] vx;
    logic signed [21:0] vy;
  } velocity_t;

  class velocity_scoreboard;
    logic [15:0] occ_thr;
    logic [23:0] obs_gain;
    logic [23:0] goal_gain;
    logic [15:0] scale;
    logic [20:0] vel_lim;
    logic [15:0] tol;
    logic [63:0] obs_q;
    logic [63:0] path_q;
    logic signed [31:0] obs_x, obs_y, obs_z;
    logic signed [31:0] path_x, path_y, path_z;
    velocity_t expected_cmds[$];
    int failures;

    function new();
      occ_thr = RST_OCC_THRESHOLD;
      obs_gain = RST_OBSTACLE_GAIN;
      goal_gain = RST_GOAL_GAIN;
      scale = RST_OUTPUT_SCALE;
      vel_lim = RST_VEL_LIMIT;
      tol = RST_DIST_TOL;
      failures = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      obs_q = DIST_NONE;
      path_q = DIST_NONE;
      {obs_x, obs_y, obs_z} = '0;
      {path_x, path_y, path_z} = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] d);
      case (idx)
        CFG_OCC_THRESHOLD: occ_thr = d[15:0];
        CFG_OBSTACLE_GAIN: obs_gain = d;
        CFG_GOAL_GAIN:     goal_gain = d;
        CFG_OUTPUT_SCALE:  scale = d[15:0];
        CFG_VEL_LIMIT:     vel_lim = d[20:0];
        CFG_DIST_TOL:      tol = d[15:0];
        default: ;
      endcase
    endfunction

    function logic [32:0] mag33(logic signed [31:0] v);
      logic signed [32:0] e;
      e = v;
      return (e < 0) ? -e : e;
    endfunction

    function logic [63:0] range_sq(logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z);
      logic [63:0] a, b, c;
      a = mag33(x);
      b = mag33(y);
      c = mag33(z);
      return a * a + b * b + c * c;
    endfunction

    function bit near_enough(logic [63:0] q);
      logic [127:0] lhs, rhs, t;
      t = {tol, 16'b0};
      lhs = 128'(q) << 32;
      rhs = t * t;
      return lhs <= rhs;
    endfunction

    function logic [39:0] cap40(logic [127:0] v);
      return (|v[127:40]) ? FORCE_CAP : v[39:0];
    endfunction

    function logic [63:0] root64(logic [63:0] x);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint repel_force(logic signed [31:0] o, logic [39:0] mag, logic [63:0] q);
      logic [127:0] m, quo, pr;
      logic [63:0] cosv, f;
      m = mag33(o);
      quo = ((m * m) << 64) / 128'(q);
      cosv = root64((|quo[127:64]) ? DIST_NONE : quo[63:0]);
      pr = 128'(mag) * 128'(cosv);
      f = pr[95:32];
      if (f > 64'(FORCE_CAP)) f = FORCE_CAP;
      return (o > 0) ? -$signed(f) : $signed(f);
    endfunction

    function longint attract_force(logic signed [31:0] p, logic [63:0] q);
      logic [127:0] n;
      logic [63:0] f;
      n = (128'(goal_gain) * 128'(mag33(p))) << 16;
      f = cap40(n / 128'(q));
      return (p < 0) ? -$signed(f) : $signed(f);
    endfunction

    function logic [21:0] to_velocity(longint f);
      logic [63:0] m;
      logic [63:0] r;
      m = (f < 0) ? -f : f;
      m = (m * 64'(scale)) >> 16;
      if (m > 64'(vel_lim)) m = vel_lim;
      r = (f < 0) ? -m : m;
      return r[21:0];
    endfunction

    function void note_input(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic [15:0] occ);
      logic [63:0] q;
      logic [39:0] mag;
      longint fx, fy;
      velocity_t cmd;
      q = range_sq(x, y, z);
      case (op)
        OP_OBSTACLE: begin
          if (occ >= occ_thr && q < obs_q) begin
            obs_q = q;
            {obs_x, obs_y, obs_z} = {x, y, z};
          end
        end
        OP_PATH: begin
          if (q < path_q) begin
            path_q = q;
            {path_x, path_y, path_z} = {x, y, z};
          end
        end
        OP_END: begin
          fx = 0;
          fy = 0;
          if (obs_q != DIST_NONE && !near_enough(obs_q)) begin
            mag = cap40(((128'(obs_gain) << 64) / 128'(obs_q)) / 128'(obs_q));
            fx += repel_force(obs_x, mag, obs_q);
            fy += repel_force(obs_y, mag, obs_q);
          end
          if (path_q != DIST_NONE && !near_enough(path_q)) begin
            fx += attract_force(path_x, path_q);
            fy += attract_force(path_y, path_q);
          end
          cmd.vx = to_velocity(fx);
          cmd.vy = to_velocity(fy);
          expected_cmds.push_back(cmd);
          clear_frame();
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [21:0] vx, logic signed [21:0] vy);
      velocity_t exp_cmd;
      if (expected_cmds.size() == 0) begin
        failures++;
        if (failures <= 10) $display("Unexpected velocity command vx=%0d vy=%0d", vx, vy);
        return;
      end
      exp_cmd = expected_cmds.pop_front();
      if (exp_cmd.vx !== vx || exp_cmd.vy !== vy) begin
        failures++;
        if (failures <= 10)
          $display("Velocity mismatch: expected vx=%0d vy=%0d, got vx=%0d vy=%0d",
                   exp_cmd.vx, exp_cmd.vy, vx, vy);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_data;
  int cycle_count = 0;
  int burst_left;
  int items_sent;

  pfv_in_if in_ch ();
  pfv_out_if out_ch ();
  velocity_scoreboard sb;

  potential_field_velocity u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver switches between always ready, coin-flip stalls and long stalls.
  initial begin : receiver
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.velocity_x, out_ch.velocity_y);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 3000);
      end else begin
        mode_left--;
      end
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic write_all(logic [15:0] thr, logic [23:0] og, logic [23:0] gg,
                           logic [15:0] sc, logic [20:0] vl, logic [15:0] tl);
    write_reg(CFG_OCC_THRESHOLD, 24'(thr));
    write_reg(CFG_OBSTACLE_GAIN, og);
    write_reg(CFG_GOAL_GAIN, gg);
    write_reg(CFG_OUTPUT_SCALE, 24'(sc));
    write_reg(CFG_VEL_LIMIT, 24'(vl));
    write_reg(CFG_DIST_TOL, 24'(tl));
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic [15:0] occ);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.point_z <= z;
    in_ch.occupancy <= occ;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(op, x, y, z, occ);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Lets the block finish all work before registers change.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly coordinates within tens of meters; now and then any 32-bit value.
  function automatic logic signed [31:0] rand_coord();
    logic [31:0] m;
    if ($urandom_range(0, 9) == 0) return $urandom;
    m = $urandom & ((32'd1 << $urandom_range(8, 22)) - 1);
    return $urandom_range(0, 1) ? -$signed(m) : $signed(m);
  endfunction

  task automatic random_frames(int count);
    int target;
    int flen;
    logic [1:0] op;
    target = items_sent + count;
    while (items_sent < target) begin
      flen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
      repeat (flen) begin
        case ($urandom_range(0, 19))
          0: op = OP_UNUSED;
          1, 2, 3, 4, 5, 6, 7, 8, 9, 10: op = OP_OBSTACLE;
          default: op = OP_PATH;
        endcase
        send_item(op, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
      end
      send_item(OP_END, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    items_sent = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_OBSTACLE;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.occupancy = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames with the register values from reset.
    send_item(OP_END, 0, 0, 0, 16'd0);
    send_item(OP_OBSTACLE, 32'sh0001_0000, 0, 0, 16'd32767);
    send_item(OP_END, 0, 0, 0, 16'd0);
    send_item(OP_OBSTACLE, 32'sh0002_0000, 32'sh0001_0000, 32'sh0000_8000, 16'd32768);
    send_item(OP_PATH, 32'sh0003_0000, -32'sh0004_0000, 0, 16'hFFFF);
    send_item(OP_END, 0, 0, 0, 16'd0);
    send_item(OP_OBSTACLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_item(OP_PATH, 0, 0, 0, 16'd0);
    send_item(OP_END, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_UNUSED, 32'h1234_5678, -32'sh0000_1000, 32'h7FFF_FFFF, 16'hFFFF);
    send_item(OP_OBSTACLE, 32'sh0001_0000, 0, 0, 16'hFFFF);
    send_item(OP_OBSTACLE, -32'sh0001_0000, 0, 0, 16'hFFFF);
    send_item(OP_PATH, 0, 32'sh0001_0000, 0, 16'd0);
    send_item(OP_PATH, 0, -32'sh0001_0000, 0, 16'd0);
    send_item(OP_END, 0, 0, 0, 16'd0);
    send_item(OP_PATH, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
    send_item(OP_OBSTACLE, 1, 0, 0, 16'hFFFF);
    send_item(OP_END, 0, 0, 0, 16'd0);
    random_frames(RANDOM_ITEMS / 5);
    drain();

    write_all(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 21'h1F_FFFF, 16'hFFFF);
    random_frames(RANDOM_ITEMS / 5);
    drain();

    write_all('0, '0, '0, '0, '0, '0);
    send_item(OP_OBSTACLE, 32'sh0000_4000, 0, 0, 16'd0);
    send_item(OP_PATH, 32'sh0003_0000, 32'sh0001_0000, 0, 16'd0);
    send_item(OP_END, 0, 0, 0, 16'd0);
    random_frames(RANDOM_ITEMS / 10);
    drain();

    write_all(16'd0, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 21'h10_0000, 16'd0);
    random_frames(RANDOM_ITEMS / 10);
    drain();

    repeat (2) begin
      write_all(16'($urandom), 24'($urandom_range(0, 24'h3F_FFFF)), 24'($urandom),
                16'($urandom), 21'($urandom_range(0, 21'h10_0000)),
                16'($urandom_range(0, 300)));
      random_frames(RANDOM_ITEMS / 5);
      drain();
    end

    if (sb.failures == 0 && sb.expected_cmds.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
